/* hw/rtl/knap_pkg.sv */
// ----------------------------------------------------------------------------
// knap_pkg: shared types and constants of the 0/1 knapsack block
// Field widths, the row memory control group and the sequencer states.
// ----------------------------------------------------------------------------
package knap_pkg;

  localparam int WEIGHT_W = 12;
  localparam int VALUE_W  = 16;
  localparam int BEST_W   = 32;
  localparam int CAP_W    = 10;

  // Enables of the row memory ports
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SWEEP    = 6'b000010,
    ST_DRAIN    = 6'b000100,
    ST_ANS_RD   = 6'b001000,
    ST_ANS_WAIT = 6'b010000,
    ST_CLEAR    = 6'b100000
  } knap_state_t;

endpackage

/* hw/rtl/knap_row_mem.sv */
// ----------------------------------------------------------------------------
// knap_row_mem: row of best values per capacity
// One write port and two read ports, read data registered on read enable.
// ----------------------------------------------------------------------------
module knap_row_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  knap_pkg::mem_ctl_t            ctl,
  input  logic [AW-1:0]                 rd_addr_a,
  input  logic [AW-1:0]                 rd_addr_b,
  output logic [knap_pkg::BEST_W-1:0]   rd_data_a,
  output logic [knap_pkg::BEST_W-1:0]   rd_data_b,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [knap_pkg::BEST_W-1:0]   wr_data
);

  logic [knap_pkg::BEST_W-1:0] row_mem_r [DEPTH];
  logic [knap_pkg::BEST_W-1:0] rd_data_a_r;
  logic [knap_pkg::BEST_W-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      row_mem_r[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_a_r <= row_mem_r[rd_addr_a];
      rd_data_b_r <= row_mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

/* hw/rtl/zero_one_knapsack.sv */
// ----------------------------------------------------------------------------
// zero_one_knapsack: 0/1 knapsack by dynamic programming over one memory row
// Rate: one item at a time. An item of weight w <= capacity c gets one memory
//   read-modify-write per entry, c down to w; a heavier item leaves the row
//   unchanged. After a last item best[c] is read into the output register once
//   the output word is free, then a clearing pass zeroes the whole row.
// Reset: synchronous, active low; a clearing pass over all MAX_CAPACITY + 1
//   entries zeroes the row before the first item is taken. Capacity resets to 0.
// ----------------------------------------------------------------------------
module zero_one_knapsack #(
  parameter int MAX_CAPACITY = 1023
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [knap_pkg::WEIGHT_W-1:0]   in_item_weight,
  input  logic [knap_pkg::VALUE_W-1:0]    in_item_value,
  input  logic                            in_last_item,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [knap_pkg::BEST_W-1:0]     out_best_value,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [knap_pkg::CAP_W-1:0]      cfg_capacity
);

  localparam int DEPTH = MAX_CAPACITY + 1;
  localparam int AW    = $clog2(DEPTH);
  // Width wide enough to compare weight, capacity register and row index
  localparam int CMPW0 = (AW > knap_pkg::WEIGHT_W) ? AW : knap_pkg::WEIGHT_W;
  localparam int CMPW  = (CMPW0 > knap_pkg::CAP_W) ? CMPW0 : knap_pkg::CAP_W;
  localparam logic [CMPW-1:0] MAX_CAP_C = CMPW'(MAX_CAPACITY);
  localparam logic [AW-1:0]   LAST_ADDR = AW'(MAX_CAPACITY);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  knap_pkg::knap_state_t state_r, state_nxt;

  logic [knap_pkg::CAP_W-1:0]   capacity_r, capacity_nxt;
  logic [AW-1:0]                clr_addr_r, clr_addr_nxt;
  logic                         s1_valid_r, s1_valid_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // item payload, sweep index and result word: no reset needed
  logic [AW-1:0]                cap_r, cap_nxt;
  logic [AW-1:0]                wt_r, wt_nxt;
  logic [knap_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic                         last_r, last_nxt;
  logic [AW-1:0]                c_r, c_nxt;
  logic [AW-1:0]                s1_addr_r, s1_addr_nxt;
  logic [knap_pkg::BEST_W-1:0]  out_best_r, out_best_nxt;

  // --------------------------------------------------------------------------
  // Row memory
  // --------------------------------------------------------------------------
  knap_pkg::mem_ctl_t           mem_ctl;
  logic [AW-1:0]                rd_addr_a, rd_addr_b, wr_addr;
  logic [knap_pkg::BEST_W-1:0]  rd_data_a, rd_data_b, wr_data;

  knap_row_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_row_mem (
    .clk       (clk),
    .ctl       (mem_ctl),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // --------------------------------------------------------------------------
  // Update datapath: best[c] = max(best[c], sat(best[c-w] + v))
  // The sweep walks c downwards, so an entry written in one cycle is never
  // read later in the same sweep: best[c-w] always lies at or below the
  // entry being read, and every write lands above it. No forwarding needed.
  // --------------------------------------------------------------------------
  logic [knap_pkg::BEST_W:0]    cand_sum;
  logic [knap_pkg::BEST_W-1:0]  cand_sat;
  logic [knap_pkg::BEST_W-1:0]  upd_value;

  always_comb begin
    cand_sum  = {1'b0, rd_data_b} + (knap_pkg::BEST_W + 1)'(val_r);
    cand_sat  = cand_sum[knap_pkg::BEST_W] ? '1 : cand_sum[knap_pkg::BEST_W-1:0];
    upd_value = (cand_sat > rd_data_a) ? cand_sat : rd_data_a;
  end

  // --------------------------------------------------------------------------
  // Item admission: clamp capacity to the row depth, spot heavy items
  // --------------------------------------------------------------------------
  logic [CMPW-1:0] cap_ext, cap_eff, wt_ext;
  logic            heavy;
  logic            in_acc, out_free;

  always_comb begin
    cap_ext  = CMPW'(capacity_r);
    cap_eff  = (cap_ext > MAX_CAP_C) ? MAX_CAP_C : cap_ext;
    wt_ext   = CMPW'(in_item_weight);
    heavy    = wt_ext > cap_eff;
  end

  assign in_ready  = (state_r == knap_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    capacity_nxt  = capacity_r;
    clr_addr_nxt  = clr_addr_r;
    cap_nxt       = cap_r;
    wt_nxt        = wt_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    c_nxt         = c_r;
    s1_valid_nxt  = 1'b0;
    s1_addr_nxt   = c_r;
    out_best_nxt  = out_best_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_ctl.rd_en = 1'b0;
    mem_ctl.wr_en = s1_valid_r;
    rd_addr_a     = c_r;
    rd_addr_b     = c_r - wt_r;
    wr_addr       = s1_addr_r;
    wr_data       = upd_value;

    if (cfg_valid && cfg_ready) begin
      capacity_nxt = cfg_capacity;
    end

    case (state_r)
      knap_pkg::ST_IDLE: begin
        if (in_acc) begin
          // latch the item word and the capacity in force
          cap_nxt  = cap_eff[AW-1:0];
          wt_nxt   = wt_ext[AW-1:0];
          val_nxt  = in_item_value;
          last_nxt = in_last_item;
          c_nxt    = cap_eff[AW-1:0];
          if (!heavy) begin
            state_nxt = knap_pkg::ST_SWEEP;
          end else if (in_last_item) begin
            state_nxt = knap_pkg::ST_ANS_RD;
          end
        end
      end
      knap_pkg::ST_SWEEP: begin
        // read best[c] and best[c-w]; write back in the following cycle
        mem_ctl.rd_en = 1'b1;
        s1_valid_nxt  = 1'b1;
        if (c_r == wt_r) begin
          state_nxt = knap_pkg::ST_DRAIN;
        end else begin
          c_nxt = c_r - 1'b1;
        end
      end
      knap_pkg::ST_DRAIN: begin
        // final write of the sweep goes out this cycle
        state_nxt = last_r ? knap_pkg::ST_ANS_RD : knap_pkg::ST_IDLE;
      end
      knap_pkg::ST_ANS_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr_a     = cap_r;
        state_nxt     = knap_pkg::ST_ANS_WAIT;
      end
      knap_pkg::ST_ANS_WAIT: begin
        // hold the answer in the read register until the output word is free
        if (out_free) begin
          out_best_nxt  = rd_data_a;
          out_valid_nxt = 1'b1;
          state_nxt     = knap_pkg::ST_CLEAR;
        end
      end
      knap_pkg::ST_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = clr_addr_r;
        wr_data       = '0;
        if (clr_addr_r == LAST_ADDR) begin
          clr_addr_nxt = '0;
          state_nxt    = knap_pkg::ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = knap_pkg::ST_CLEAR;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= knap_pkg::ST_CLEAR;
      capacity_r  <= '0;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      capacity_r  <= capacity_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cap_r      <= cap_nxt;
    wt_r       <= wt_nxt;
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    c_r        <= c_nxt;
    s1_addr_r  <= s1_addr_nxt;
    out_best_r <= out_best_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_best_value = out_best_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> state_r == knap_pkg::ST_CLEAR)
    else $error("row clearing pass not started after reset");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == knap_pkg::ST_SWEEP |-> c_r >= wt_r)
    else $error("sweep index fell below item weight");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.wr_en && mem_ctl.rd_en) |-> (rd_addr_a != wr_addr && rd_addr_b != wr_addr))
    else $error("row entry read in the cycle it is written");

  a_answer_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == knap_pkg::ST_ANS_WAIT))
    else $error("result word loaded outside the answer state");

endmodule
